// ----- hdl/mpr_pkg.sv -----
// Shared types, constants and the median edge prediction function.
package mpr_pkg;

    localparam int PIX_W = 8;
    localparam int LW_W  = 13;
    localparam int FH_W  = 16;
    localparam int CFG_W = 16;

    typedef enum logic [0:0] {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    // LOCO-I median edge prediction from left (a), upper (b) and upper-left (c).
    function automatic t_pix med_predict(input t_pix a, input t_pix b, input t_pix c);
        t_pix lo;
        t_pix hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c >= hi) begin
            med_predict = lo;
        end else if (c <= lo) begin
            med_predict = hi;
        end else begin
            med_predict = a + b - c;
        end
    endfunction

endpackage

// ----- hdl/mpr_line_store.sv -----
// Line store memory with a registered read and write-to-read forwarding.
module mpr_line_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [mpr_pkg::PIX_W-1:0] i_wr_data,
    output logic [mpr_pkg::PIX_W-1:0] o_rd_data
);
    import mpr_pkg::*;

    t_pix       r_mem [DEPTH];
    t_pix       r_rdata;
    t_pix       r_fwd_data;
    logic       r_fwd_hit;
    logic       n_fwd_hit;

    assign n_fwd_hit = i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // A read that collides with a write in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= n_fwd_hit;
        end
        if (n_fwd_hit) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rdata;

    a_fwd_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_fwd_hit |=> (o_rd_data == $past(i_wr_data)))
        else $error("line store forwarding returned stale data");

endmodule

// ----- hdl/med_predictor_reconstruct.sv -----
// Median edge predictor reconstruction: residual stream in, reconstructed pixels out.
// Path: an accepted residual beat is registered in stage 1 with its line store read, then
//   its pixel in the output register. Throughput: one pixel per cycle while i_ready is high;
//   the store read and the left-pixel feedback through the adder never stall it.
// Reset (synchronous, active low) clears the counters, pipeline valids and neighbor
//   registers and loads line_width 640 and frame_height 480; the line store is not cleared.
module med_predictor_reconstruct #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  mpr_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [mpr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mpr_pkg::PIX_W-1:0]     i_residual,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mpr_pkg::PIX_W-1:0]     o_pixel,
    output logic                          o_frame_end
);
    import mpr_pkg::*;

    // Column counter indexes the line store directly; the width compare runs wide
    // enough to hold both MAX_WIDTH and the 13-bit register.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > LW_W) ? CW + 1 : LW_W;

    // Configuration registers.
    logic [LW_W-1:0]  r_line_width;
    logic [FH_W-1:0]  r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LW_W'(640);
            r_frame_height <= FH_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective limits: zero acts as one, and the width is clamped to the store size.
    logic [EW-1:0]   eff_width;
    logic [FH_W:0]   eff_height;

    always_comb begin
        eff_width = EW'(r_line_width);
        if (eff_width == '0) begin
            eff_width = EW'(1);
        end
        if (eff_width > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end
        eff_height = (r_frame_height == '0) ? (FH_W+1)'(1) : {1'b0, r_frame_height};
    end

    // Stage 0: accept a beat, issue the line store read and step the raster counters.
    logic [CW-1:0]   r_col;
    logic [FH_W-1:0] r_row;
    logic            in_fire;
    logic            s1_fire;
    logic            s1_free;
    logic            last_col;
    logic            last_row;

    // Stage 1 holds one beat while the store read completes.
    logic            r_s1_valid;
    t_pix            r_s1_residual;
    logic            r_s1_pass;
    logic            r_s1_frame_end;
    logic [CW-1:0]   r_s1_addr;

    // Output register decouples the sink from the pipeline.
    logic            r_out_valid;
    t_pix            r_out_pixel;
    logic            r_out_frame_end;

    assign last_col = (EW'(r_col) + EW'(1)) >= eff_width;
    assign last_row = ({1'b0, r_row} + (FH_W+1)'(1)) >= eff_height;

    assign s1_free = !r_out_valid || i_ready;
    assign s1_fire = r_s1_valid && s1_free;
    assign o_ready = !r_s1_valid || s1_free;
    assign in_fire = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + FH_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
        if (in_fire) begin
            r_s1_residual  <= i_residual;
            r_s1_pass      <= (r_row == '0) || (r_col == '0);
            r_s1_frame_end <= last_col && last_row;
            r_s1_addr      <= r_col;
        end
    end

    // Line store: the previous reconstructed row, written back as each pixel resolves.
    t_pix upper;
    t_pix pix;

    mpr_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_col),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (pix),
        .o_rd_data (upper)
    );

    // Stage 1: prediction from left, upper and upper-left, then the modulo-256 add; pixels in
    // the first row or column take the residual as it is. Left and upper-left update only when
    // a beat leaves this stage, so the next beat always sees its true neighbors even across stalls.
    t_pix r_left;
    t_pix r_upper_left;

    assign pix = r_s1_pass ? r_s1_residual
                           : r_s1_residual + med_predict(r_left, upper, r_upper_left);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_upper_left <= '0;
        end else if (s1_fire) begin
            r_left       <= pix;
            r_upper_left <= upper;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire) begin
            r_out_pixel     <= pix;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel     = r_out_pixel;
    assign o_frame_end = r_out_frame_end;

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted beat did not reach stage 1");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_free) |=> (r_s1_valid && $stable(r_s1_residual)
                                      && $stable(r_s1_addr)))
        else $error("stage 1 lost a stalled beat");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (o_valid && (o_pixel == $past(pix))))
        else $error("resolved pixel did not reach the output register");

    a_first_col_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_col == '0)) |=> r_s1_pass)
        else $error("first column pixel not marked pass-through");

endmodule

// ----- bench/recon_checker.sv -----
// Checker for the median edge reconstruction block: predicts every pixel and compares.
module recon_checker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  mpr_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [mpr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  mpr_pkg::t_pix                 i_residual,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  mpr_pkg::t_pix                 i_pixel,
    input  logic                          i_frame_end,
    output int unsigned                   o_pending,
    output int unsigned                   o_errors
);
    import mpr_pkg::*;

    typedef struct packed {
        t_pix pixel;
        logic frame_end;
    } t_recon;

    // Shadow copy of the registers and of the block's neighbor state.
    logic [LW_W-1:0] line_width_q;
    logic [FH_W-1:0] frame_height_q;
    t_pix            row_copy [MAX_WIDTH];
    t_pix            left_pix;
    t_pix            upper_left_pix;
    int unsigned     col_pos;
    logic [FH_W-1:0] row_pos;

    t_recon          expected_pixels [$];
    int unsigned     mismatches;

    assign o_errors = mismatches;

    function automatic t_pix median_edge(input t_pix a, input t_pix b, input t_pix c);
        t_pix lo;
        t_pix hi;
        if (a > b) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        if (c >= hi) begin
            return lo;
        end
        if (c <= lo) begin
            return hi;
        end
        return t_pix'(a + b - c);
    endfunction

    function automatic t_recon reconstruct_pixel(input t_pix residual);
        int unsigned w;
        int unsigned h;
        t_pix        upper;
        t_pix        pix;
        logic        last_col;
        logic        last_row;
        t_recon      r;
        w = (line_width_q == 0) ? 1 : int'(line_width_q);
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        h = (frame_height_q == 0) ? 1 : int'(frame_height_q);
        upper    = row_copy[col_pos];
        last_col = (col_pos + 1 >= w);
        last_row = (int'(row_pos) + 1 >= h);
        // The first row and the first column carry no prediction.
        if (row_pos == 0 || col_pos == 0) begin
            pix = residual;
        end else begin
            pix = t_pix'(residual + median_edge(left_pix, upper, upper_left_pix));
        end
        upper_left_pix    = upper;
        row_copy[col_pos] = pix;
        left_pix          = pix;
        r.pixel     = pix;
        r.frame_end = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_recon got;
        t_recon want;
        t_recon fresh;
        if (!i_rst_n) begin
            line_width_q   = 13'd640;
            frame_height_q = 16'd480;
            foreach (row_copy[k]) begin
                row_copy[k] = '0;
            end
            left_pix       = '0;
            upper_left_pix = '0;
            col_pos        = 0;
            row_pos        = '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINE_WIDTH: begin
                        line_width_q = i_cfg_data[LW_W-1:0];
                    end
                    CFG_FRAME_HEIGHT: begin
                        frame_height_q = i_cfg_data[FH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.pixel     = i_pixel;
                got.frame_end = i_frame_end;
                if (expected_pixels.size() == 0) begin
                    flag_mismatch($sformatf("pixel %0d frame_end %0b with none expected",
                                            got.pixel, got.frame_end));
                end else begin
                    want = expected_pixels.pop_front();
                    if (got != want) begin
                        flag_mismatch($sformatf(
                            "got pixel %0d frame_end %0b, expected pixel %0d frame_end %0b",
                            got.pixel, got.frame_end, want.pixel, want.frame_end));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                fresh = reconstruct_pixel(i_residual);
                expected_pixels = {expected_pixels, fresh};
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

// ----- bench/tb.sv -----
// Bench top: drives residual beats and register writes, and reports the verdict.
module tb;
    import mpr_pkg::*;

    localparam int MAX_WIDTH    = 4096;
    localparam int TARGET_BEATS = 1550;

    // All block inputs start at known values.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    t_cfg_idx          cfg_idx   = CFG_LINE_WIDTH;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              res_valid = 1'b0;
    logic              res_ready;
    t_pix              residual  = '0;
    logic              pix_valid;
    logic              pix_ready = 1'b0;
    t_pix              pixel;
    logic              frame_end;

    int unsigned       pending;
    int unsigned       errors;

    // Stimulus bookkeeping. The bench follows where the next beat lands in the frame,
    // so that a register change never makes the block read a line store entry that
    // has not been written yet.
    int unsigned       cur_w = 640;
    int unsigned       cur_h = 480;
    int unsigned       at_col = 0;
    int unsigned       at_row = 0;
    int unsigned       beats_sent = 0;
    int unsigned       reg_writes = 0;

    // When set, the matching side runs without any idle cycles.
    bit                steady_input = 1'b0;
    bit                ready_steady = 1'b0;
    int unsigned       stall_left = 0;

    always #10 clk = ~clk;

    med_predictor_reconstruct #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (res_valid),
        .o_ready    (res_ready),
        .i_residual (residual),
        .o_valid    (pix_valid),
        .i_ready    (pix_ready),
        .o_pixel    (pixel),
        .o_frame_end(frame_end)
    );

    recon_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (res_valid),
        .i_in_ready (res_ready),
        .i_residual (residual),
        .i_out_valid(pix_valid),
        .i_out_ready(pix_ready),
        .i_pixel    (pixel),
        .i_frame_end(frame_end),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // Idle lengths: mostly none, often short, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Residual content: uniform bytes, small signed steps around zero (smooth
    // images, where the median predictor switches between its branches a lot),
    // and the two extremes.
    function automatic t_pix next_residual();
        int unsigned roll;
        roll = $urandom_range(3);
        if (roll < 2) begin
            return t_pix'($urandom_range(255));
        end
        if (roll == 2) begin
            return t_pix'($urandom_range(9) + 252);
        end
        return $urandom_range(1) ? 8'hFF : 8'h00;
    endfunction

    function automatic int unsigned width_eff(input logic [LW_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        if (v > MAX_WIDTH) begin
            return MAX_WIDTH;
        end
        return int'(v);
    endfunction

    // The receiver stalls at random; in steady stretches it stays ready.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            pix_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            pix_ready  <= 1'b1;
            stall_left <= ready_steady ? 0 : pick_gap();
        end
    end

    // Offers one residual beat and returns at the edge that accepts it. Valid is
    // only lowered when a gap follows, so back-to-back beats keep it high.
    task automatic send_residual(input t_pix value);
        int unsigned gap;
        gap = steady_input ? 0 : pick_gap();
        if (gap != 0) begin
            res_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        res_valid <= 1'b1;
        residual  <= value;
        do @(posedge clk); while (!res_ready);
        beats_sent++;
        if (at_col + 1 >= cur_w) begin
            at_col = 0;
            at_row = (at_row + 1 >= cur_h) ? 0 : at_row + 1;
        end else begin
            at_col++;
        end
    endtask

    // Register writes happen only once every pixel in flight has come out. The first
    // edge is waited out so that the pending count already includes the last beat.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        res_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
        if (idx == CFG_LINE_WIDTH) begin
            cur_w = width_eff(data[LW_W-1:0]);
        end else begin
            cur_h = (data[FH_W-1:0] == 0) ? 1 : int'(data[FH_W-1:0]);
        end
    endtask

    initial begin
        int unsigned      roll;
        int unsigned      n;
        longint           left_in_frame;
        logic [LW_W-1:0]  w_val;
        logic [FH_W-1:0]  h_val;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (640 wide, 480 high): a few first-row beats that must pass
        // straight through, with the residual extremes among them.
        send_residual(8'h00); send_residual(8'hFF); send_residual(8'h01);
        send_residual(8'h80); send_residual(8'h7F);

        // Width shrinks to 2 in the middle of the first row: the column counter is
        // already past the new limit, so the next beat finishes there and wraps.
        // The following rows then run the median prediction on a 2-pixel image.
        write_reg(CFG_LINE_WIDTH, 16'd2);
        send_residual(8'hFF); send_residual(8'h00); send_residual(8'h80);
        send_residual(8'h7F); send_residual(8'h01); send_residual(8'hFE);
        send_residual(8'h40); send_residual(8'hC0); send_residual(8'h10);

        // A height of zero acts as one, and the row counter sits beyond it, so this
        // row is the last of its frame.
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        send_residual(8'h33); send_residual(8'hCC);

        // A width of zero acts as one: every pixel is a whole frame.
        write_reg(CFG_LINE_WIDTH, 16'd0);
        send_residual(8'hAA); send_residual(8'h55); send_residual(8'hFF);

        // A width beyond the line store acts as the store size.
        write_reg(CFG_LINE_WIDTH, 16'h1FFF);
        send_residual(8'h12); send_residual(8'hED); send_residual(8'h00);

        // Tallest frame, then a narrow width again in the middle of the row.
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        write_reg(CFG_LINE_WIDTH, 16'd3);
        send_residual(8'h90); send_residual(8'h21); send_residual(8'hF0);
        send_residual(8'h0F);

        // Random part: each pass picks new settings, then streams a run of beats.
        while (beats_sent < TARGET_BEATS) begin
            roll = $urandom_range(2);
            if (roll != 0) begin
                n = $urandom_range(99);
                if (n < 60) begin
                    h_val = FH_W'($urandom_range(1, 4));
                end else if (n < 75) begin
                    h_val = FH_W'($urandom_range(5, 20));
                end else if (n < 83) begin
                    h_val = '0;
                end else if (n < 90) begin
                    h_val = 16'hFFFF;
                end else begin
                    h_val = FH_W'($urandom_range(16'hFFFF));
                end
                write_reg(CFG_FRAME_HEIGHT, h_val);
            end
            if (roll != 1) begin
                n = $urandom_range(99);
                if (n < 60) begin
                    w_val = LW_W'($urandom_range(1, 8));
                end else if (n < 80) begin
                    w_val = LW_W'($urandom_range(9, 40));
                end else if (n < 86) begin
                    w_val = '0;
                end else if (n < 90) begin
                    w_val = 13'd4096;
                end else if (n < 94) begin
                    w_val = LW_W'($urandom_range(4097, 8191));
                end else begin
                    w_val = LW_W'($urandom_range(41, 4095));
                end
                // Past the first row a wider line would reach store entries that the previous
                // row never wrote, so only widths no wider than the current one go in there.
                if (at_row != 0 && width_eff(w_val) > cur_w) begin
                    w_val = LW_W'($urandom_range(1, cur_w));
                end
                // The bits above the width field are don't-care; toggle them too.
                write_reg(CFG_LINE_WIDTH, {3'($urandom_range(7)), w_val});
            end

            steady_input = ($urandom_range(3) == 0);
            ready_steady = ($urandom_range(3) == 0);
            n = $urandom_range(10, 90);
            repeat (n) send_residual(next_residual());

            // Sometimes finish the frame when it is close, so that the next settings
            // start on a clean frame boundary.
            if ($urandom_range(1) == 1 && at_row < cur_h && at_col < cur_w) begin
                left_in_frame = longint'(cur_h - at_row - 1) * cur_w + (cur_w - at_col);
                if (left_in_frame <= 60) begin
                    while (at_col != 0 || at_row != 0) send_residual(next_residual());
                end
            end
        end

        // Drain: wait until every predicted pixel has come out, and then wait on to catch
        // anything the block emits on top of that.
        steady_input = 1'b0;
        res_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Streamed %0d residual beats through %0d register writes,", beats_sent,
                 reg_writes);
        $display("covering widths from one pixel to the full line store and all heights.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatching pixel beats.", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, so hitting it means a hang.
    initial begin
        #(20 * 1000000);
        $display("Timeout with %0d pixels still outstanding.", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
